>>> hw/rtl/pmp_pkg.sv
// Package for the motor position PID block: widths, constants, microcode
// control word and status types. No dependencies.
package pmp_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS = 10;
   localparam int SUM_W       = 24;
   localparam int ERR_W       = SAMPLE_BITS + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int GAIN_W      = 16;
   localparam int PERIOD_W    = 16;
   localparam int ACC_W       = 44;
   localparam int QUO_W       = ACC_W - 8;
   localparam int MUL_W       = SUM_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int EFFORT_W    = 11;
   localparam int SPEED_W     = 7;
   localparam int DUTY_W      = 17;
   localparam int DIVIDEND_W  = 23;
   localparam int STEP_W      = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Arithmetic constants
   localparam int EFFORT_LIMIT = 1000;
   localparam logic signed [MUL_W-1:0] RECIP_TEN     = MUL_W'(205);      // 2^11 / 10, rounded up
   localparam int                      RECIP_TEN_SHIFT = 11;
   localparam logic signed [MUL_W-1:0] RECIP_HUNDRED = MUL_W'(10737419); // 2^30 / 100, rounded up
   localparam int                      RECIP_HUNDRED_SHIFT = 30;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS    = ACC_W'(255);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_BITS-1:0] SETPOINT_RST = SAMPLE_BITS'(512);
   localparam logic [GAIN_W-1:0]      GAIN_P_RST   = GAIN_W'(512);
   localparam logic [GAIN_W-1:0]      GAIN_I_RST   = GAIN_W'(0);
   localparam logic [GAIN_W-1:0]      GAIN_D_RST   = GAIN_W'(128);
   localparam logic [SAMPLE_BITS-1:0] DEADBAND_RST = SAMPLE_BITS'(2);
   localparam logic [PERIOD_W-1:0]    PERIOD_RST   = PERIOD_W'(200);

   // Program step address that is a jump target
   localparam logic [STEP_W-1:0] STEP_EFFORT = 4'd5;

   // Multiplier operand selection
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_P,
      MUL_I,
      MUL_D,
      MUL_SPEED,
      MUL_PERIOD,
      MUL_RECIP
   } mul_sel_type;

   // Jump conditions
   typedef enum logic {
      COND_NONE,
      COND_DEAD
   } cond_type;

   // One microcode word
   typedef struct packed {
      logic              err_en;
      mul_sel_type       mul_sel;
      logic              acc_add;
      logic              effort_en;
      logic              speed_en;
      logic              out_en;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctrl_word_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic dead;
      logic out_blocked;
   } dp_status_type;

   // Sequencer states
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

endpackage

>>> hw/rtl/pmp_ucode_rom.sv
// Microcode table for the PID sequence: one control word per step.
// Depends on pmp_pkg.
module pmp_ucode_rom
   import pmp_pkg::*;
(
   input  logic [STEP_W-1:0] step,
   output ctrl_word_type     ctrl
);

   // Program: error, three products into the sum, effort, speed, duty
   always_comb begin
      ctrl = '{err_en: 1'b0, mul_sel: MUL_NONE, acc_add: 1'b0, effort_en: 1'b0,
               speed_en: 1'b0, out_en: 1'b0, cond: COND_NONE, target: '0,
               last: 1'b0};
      case (step)
         4'd0: begin
            ctrl.err_en = 1'b1;
         end
         4'd1: begin
            ctrl.mul_sel = MUL_P;
            ctrl.cond    = COND_DEAD;
            ctrl.target  = STEP_EFFORT;
         end
         4'd2: begin
            ctrl.mul_sel = MUL_I;
            ctrl.acc_add = 1'b1;
         end
         4'd3: begin
            ctrl.mul_sel = MUL_D;
            ctrl.acc_add = 1'b1;
         end
         4'd4: begin
            ctrl.acc_add = 1'b1;
         end
         4'd5: begin
            ctrl.effort_en = 1'b1;
         end
         4'd6: begin
            ctrl.mul_sel = MUL_SPEED;
         end
         4'd7: begin
            ctrl.speed_en = 1'b1;
         end
         4'd8: begin
            ctrl.mul_sel = MUL_PERIOD;
         end
         4'd9: begin
            ctrl.mul_sel = MUL_RECIP;
         end
         4'd10: begin
            ctrl.out_en = 1'b1;
            ctrl.last   = 1'b1;
         end
         default: begin
            ctrl.last = 1'b1;
         end
      endcase
   end

endmodule

>>> hw/rtl/pmp_sequencer.sv
// Step counter and jump logic for the PID microprogram.
// Depends on pmp_pkg.
module pmp_sequencer
   import pmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ctrl_word_type     ctrl,
   input  dp_status_type     status,
   output logic [STEP_W-1:0] step,
   output logic              active,
   output logic              idle
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              hold;
   logic              jump;

   assign hold = ctrl.out_en && status.out_blocked;
   assign jump = (ctrl.cond == COND_DEAD) && status.dead;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            if (!hold && !jump && ctrl.last) state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Step counter
   always_comb begin
      step_in = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
         end
         SEQ_RUN: begin
            if (hold)            step_in = step_ff;
            else if (jump)       step_in = ctrl.target;
            else if (ctrl.last)  step_in = '0;
            else                 step_in = step_ff + 1'b1;
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // Outputs
   always_comb begin
      active = 1'b0;
      idle   = 1'b0;
      case (state_ff)
         SEQ_IDLE: idle   = 1'b1;
         SEQ_RUN:  active = 1'b1;
         default:  idle   = 1'b0;
      endcase
   end

   assign step = step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> hw/rtl/pmp_datapath.sv
// PID datapath: config registers, error and sum state, shared multiplier,
// accumulator, clamp, scaling and the result register. Depends on pmp_pkg.
module pmp_datapath
   import pmp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_word_type                 ctrl,
   input  logic                          active,
   input  logic                          load,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_idx,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          out_ready,
   output dp_status_type                 status,
   output logic                          out_valid,
   output logic [DUTY_W-1:0]             left_duty,
   output logic [DUTY_W-1:0]             right_duty,
   output logic                          direction,
   output logic [SPEED_W-1:0]            speed_percent,
   output logic signed [EFFORT_W-1:0]    effort
);

   // Config registers
   logic [SAMPLE_BITS-1:0] setpoint_ff, deadband_ff;
   logic [GAIN_W-1:0]      gain_p_ff, gain_i_ff, gain_d_ff;
   logic [PERIOD_W-1:0]    period_ff;

   // Working registers
   logic [SAMPLE_BITS-1:0]     sample_ff;
   logic signed [ERR_W-1:0]    e_ff, prev_ff, e_in;
   logic signed [DIFF_W-1:0]   de_ff, de_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SUM_W:0]      sum_wide;
   logic                       dir_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [QUO_W-1:0]    quo;
   logic signed [EFFORT_W-1:0] effort_ff, effort_in;
   logic [EFFORT_W-1:0]        effort_abs;
   logic [SPEED_W-1:0]         speed_ff;
   logic signed [MUL_W-1:0]    opa, opb;
   logic [ERR_W-1:0]           mag_e;
   logic [DUTY_W-1:0]          duty;
   logic                       dead;
   logic                       out_blocked;

   // Result register
   logic                       out_valid_ff;
   logic [DUTY_W-1:0]          left_ff, right_ff;
   logic                       out_dir_ff;
   logic [SPEED_W-1:0]         out_speed_ff;
   logic signed [EFFORT_W-1:0] out_effort_ff;
   logic                       out_write;

   localparam logic signed [QUO_W-1:0]    QUO_POS    = QUO_W'(EFFORT_LIMIT);
   localparam logic signed [QUO_W-1:0]    QUO_NEG    = -QUO_POS;
   localparam logic signed [EFFORT_W-1:0] EFFORT_POS = EFFORT_W'(EFFORT_LIMIT);
   localparam logic signed [EFFORT_W-1:0] EFFORT_NEG = -EFFORT_POS;
   localparam logic signed [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

   // Config writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RST;
         gain_p_ff   <= GAIN_P_RST;
         gain_i_ff   <= GAIN_I_RST;
         gain_d_ff   <= GAIN_D_RST;
         deadband_ff <= DEADBAND_RST;
         period_ff   <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_SETPOINT: setpoint_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_GAIN_P:   gain_p_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:   gain_i_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:   gain_d_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_DEADBAND: deadband_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_PERIOD:   period_ff   <= csr_wdata[PERIOD_W-1:0];
            default:      setpoint_ff <= setpoint_ff;
         endcase
      end
   end

   // Error, error difference and saturating sum
   always_comb begin
      e_in     = $signed({1'b0, setpoint_ff}) - $signed({1'b0, sample_ff});
      de_in    = $signed({e_in[ERR_W-1], e_in}) - $signed({prev_ff[ERR_W-1], prev_ff});
      sum_wide = $signed({sum_ff[SUM_W-1], sum_ff})
               + $signed({{(SUM_W+1-ERR_W){e_in[ERR_W-1]}}, e_in});
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
         sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      else
         sum_in = sum_wide[SUM_W-1:0];
   end

   // Deadband test on the stored error
   assign mag_e = e_ff[ERR_W-1] ? ERR_W'(-e_ff) : ERR_W'(e_ff);
   assign dead  = mag_e <= {1'b0, deadband_ff};

   // Multiplier operand select
   assign effort_abs = effort_ff[EFFORT_W-1] ? EFFORT_W'(-effort_ff) : EFFORT_W'(effort_ff);

   always_comb begin
      opa = '0;
      opb = '0;
      case (ctrl.mul_sel)
         MUL_P: begin
            opa = {{(MUL_W-GAIN_W){1'b0}}, gain_p_ff};
            opb = {{(MUL_W-ERR_W){e_ff[ERR_W-1]}}, e_ff};
         end
         MUL_I: begin
            opa = {{(MUL_W-GAIN_W){1'b0}}, gain_i_ff};
            opb = {sum_ff[SUM_W-1], sum_ff};
         end
         MUL_D: begin
            opa = {{(MUL_W-GAIN_W){1'b0}}, gain_d_ff};
            opb = {{(MUL_W-DIFF_W){de_ff[DIFF_W-1]}}, de_ff};
         end
         MUL_SPEED: begin
            opa = {{(MUL_W-EFFORT_W){1'b0}}, effort_abs};
            opb = RECIP_TEN;
         end
         MUL_PERIOD: begin
            opa = {{(MUL_W-SPEED_W){1'b0}}, speed_ff};
            opb = {{(MUL_W-PERIOD_W){1'b0}}, period_ff};
         end
         MUL_RECIP: begin
            opa = {{(MUL_W-DIVIDEND_W){1'b0}}, prod_ff[DIVIDEND_W-1:0]};
            opb = RECIP_HUNDRED;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // Accumulate, then divide by 256 toward zero and clamp
   assign acc_in = acc_ff + $signed(prod_ff[ACC_W-1:0]);
   assign rnd    = acc_ff + (acc_ff[ACC_W-1] ? ROUND_BIAS : '0);
   assign quo    = rnd[ACC_W-1:8];

   always_comb begin
      if (quo > QUO_POS)      effort_in = EFFORT_POS;
      else if (quo < QUO_NEG) effort_in = EFFORT_NEG;
      else                    effort_in = quo[EFFORT_W-1:0];
   end

   // Duty: quotient by 100, plus one when driving
   assign duty = prod_ff[RECIP_HUNDRED_SHIFT +: DUTY_W]
               + {{(DUTY_W-1){1'b0}}, speed_ff != '0};

   assign out_write   = active && ctrl.out_en && !out_blocked;
   assign out_blocked = out_valid_ff && !out_ready;
   assign status      = '{dead: dead, out_blocked: out_blocked};

   // Sample capture and datapath registers
   always_ff @(posedge clock) begin
      if (load) sample_ff <= sample;
      if (active) begin
         if (ctrl.err_en) begin
            e_ff   <= e_in;
            de_ff  <= de_in;
            dir_ff <= e_in[ERR_W-1];
            acc_ff <= '0;
         end else if (ctrl.acc_add) begin
            acc_ff <= acc_in;
         end
         if (ctrl.mul_sel != MUL_NONE) prod_ff <= opa * opb;
         if (ctrl.effort_en) effort_ff <= effort_in;
         if (ctrl.speed_en)  speed_ff  <= prod_ff[RECIP_TEN_SHIFT +: SPEED_W];
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         sum_ff  <= '0;
      end else if (active && ctrl.err_en) begin
         prev_ff <= e_in;
         sum_ff  <= sum_in;
      end
   end

   // Result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_write) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         left_ff       <= dir_ff ? '0 : duty;
         right_ff      <= dir_ff ? duty : '0;
         out_dir_ff    <= dir_ff;
         out_speed_ff  <= speed_ff;
         out_effort_ff <= effort_ff;
      end
   end

   assign out_valid     = out_valid_ff;
   assign left_duty     = left_ff;
   assign right_duty    = right_ff;
   assign direction     = out_dir_ff;
   assign speed_percent = out_speed_ff;
   assign effort        = out_effort_ff;

endmodule

>>> hw/rtl/pid_motor_position_pwm.sv
// An accepted request beat runs the microprogram to a result beat on rsp_valid;
// inside the deadband the product steps are skipped. A new request is accepted
// only while idle, so one sample is in work at a time; the last step waits while
// an unaccepted result beat is pending. Reset clears the sequencer, result valid,
// error sum and previous error, and loads the register defaults.
// Depends on pmp_pkg, pmp_ucode_rom, pmp_sequencer, pmp_datapath.
module pid_motor_position_pwm
   import pmp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_BITS-1:0]     req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DUTY_W-1:0]          rsp_left_duty,
   output logic [DUTY_W-1:0]          rsp_right_duty,
   output logic                       rsp_direction,
   output logic [SPEED_W-1:0]         rsp_speed_percent,
   output logic signed [EFFORT_W-1:0] rsp_effort,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   ctrl_word_type     ctrl;
   dp_status_type     status;
   logic [STEP_W-1:0] step;
   logic              active;
   logic              idle;
   logic              start;

   // Request beat starts the program
   assign req_ready = idle;
   assign start     = req_valid && req_ready;
   assign csr_ready = 1'b1;

   pmp_ucode_rom u_rom (
      .step (step),
      .ctrl (ctrl)
   );

   pmp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ctrl   (ctrl),
      .status (status),
      .step   (step),
      .active (active),
      .idle   (idle)
   );

   pmp_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .active        (active),
      .load          (start),
      .sample        (req_sample),
      .csr_we        (csr_valid),
      .csr_idx       (csr_index),
      .csr_wdata     (csr_data),
      .out_ready     (rsp_ready),
      .status        (status),
      .out_valid     (rsp_valid),
      .left_duty     (rsp_left_duty),
      .right_duty    (rsp_right_duty),
      .direction     (rsp_direction),
      .speed_percent (rsp_speed_percent),
      .effort        (rsp_effort)
   );

endmodule
